// File: src/bfsp_pkg.sv
// Shared constants, types and bit-ordering functions of the bit field stream packer.
package bfsp_pkg;

	localparam int CAPACITY_BYTES = 256;
	localparam int CAP_BITS       = CAPACITY_BYTES * 8;
	localparam int ADDR_W         = $clog2(CAPACITY_BYTES);
	localparam int POS_W          = $clog2(CAP_BITS + 1);
	localparam int BYTE_W         = 8;
	localparam int VALUE_W        = 64;
	localparam int WIDTH_W        = 7;
	localparam int MODE_W         = 3;
	localparam int STATUS_W       = 2;
	localparam int POSITION_OUT_W = 12;
	localparam int LANES          = VALUE_W / BYTE_W;
	localparam int WIN_BYTES      = LANES + 1;
	localparam int WIN_W          = WIN_BYTES * BYTE_W;
	localparam int CNT_W          = $clog2(WIN_BYTES + 1);

	localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ALIGN  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_REWIND = 3'd4;

	localparam logic [WIDTH_W-1:0] MAX_FIELD_W = 7'd64;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_READ_PAST = 2'd1,
		ST_CAPACITY  = 2'd2,
		ST_PROTECTED = 2'd3
	} status_t;

	typedef struct packed {
		logic load;
		logic decide;
		logic step;
		logic publish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_access;
		logic access_done;
		logic out_free;
	} dp_status_t;

	// Number of field bits that fall into chunk i: eight, the short tail, or none.
	function automatic logic [3:0] lane_size(input logic [WIDTH_W-1:0] w, input int i);
		logic [WIDTH_W:0] lo;
		logic [WIDTH_W:0] wx;
		lo = (WIDTH_W + 1)'(BYTE_W * i);
		wx = {1'b0, w};
		if (wx >= lo + (WIDTH_W + 1)'(BYTE_W))
			return 4'd8;
		else if (wx > lo)
			return 4'(wx - lo);
		else
			return 4'd0;
	endfunction

	// Reorders a field so that stream bit j lands at bit (63 - j).
	function automatic logic [VALUE_W-1:0] pack_order(input logic [VALUE_W-1:0] v,
			input logic [WIDTH_W-1:0] w);
		logic [VALUE_W-1:0] t;
		logic [3:0] c;
		logic [BYTE_W-1:0] b;
		t = '0;
		for (int i = 0; i < LANES; i++) begin
			c = lane_size(w, i);
			b = v[BYTE_W*i +: BYTE_W] << (4'd8 - c);
			t[VALUE_W-1-BYTE_W*i -: BYTE_W] = b;
		end
		return t;
	endfunction

	// Inverse of pack_order on a left-justified, masked stream word.
	function automatic logic [VALUE_W-1:0] unpack_order(input logic [VALUE_W-1:0] u,
			input logic [WIDTH_W-1:0] w);
		logic [VALUE_W-1:0] v;
		logic [3:0] c;
		logic [BYTE_W-1:0] b;
		v = '0;
		for (int i = 0; i < LANES; i++) begin
			c = lane_size(w, i);
			b = u[VALUE_W-1-BYTE_W*i -: BYTE_W] >> (4'd8 - c);
			v[BYTE_W*i +: BYTE_W] = b;
		end
		return v;
	endfunction

endpackage

// File: src/bfsp_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module bfsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/bfsp_ctrl.sv
// Controller state machine sequencing one beat: decide, byte access if needed, result.
module bfsp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bfsp_pkg::dp_status_t  sts,
	output bfsp_pkg::ctrl_cmd_t   cmd
);
	import bfsp_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECIDE = 4'b0010,
		S_ACCESS = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = sts.need_access ? S_ACCESS : S_FINISH;
			end
			S_ACCESS: begin
				cmd.step = 1'b1;
				if (sts.access_done)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// File: src/bfsp_datapath.sv
// Datapath with position registers, byte store, access window and result register.
module bfsp_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bfsp_pkg::ctrl_cmd_t                    cmd,
	output bfsp_pkg::dp_status_t                   sts,
	input  logic                                   cfg_valid,
	input  logic                                   write_protect,
	input  logic [bfsp_pkg::MODE_W-1:0]            mode,
	input  logic [bfsp_pkg::VALUE_W-1:0]           field_value,
	input  logic [bfsp_pkg::WIDTH_W-1:0]           field_width,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [bfsp_pkg::VALUE_W-1:0]           read_value,
	output logic [bfsp_pkg::POSITION_OUT_W-1:0]    position_bits,
	output logic [bfsp_pkg::STATUS_W-1:0]          status
);
	import bfsp_pkg::*;

	logic                      wp_q;
	logic [MODE_W-1:0]         mode_q;
	logic [VALUE_W-1:0]        val_q;
	logic [WIDTH_W-1:0]        w_q;
	logic [POS_W-1:0]          pos_q;
	logic [POS_W-1:0]          written_q;
	logic [CAPACITY_BYTES-1:0] vld_q;
	status_t                   st_q;
	logic                      rd_ok_q;
	logic [ADDR_W-1:0]         base_q;
	logic [2:0]                off_q;
	logic [CNT_W-1:0]          nb_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      rvld_q;
	logic [0:WIN_BYTES-1][BYTE_W-1:0] win_q;
	logic [0:WIN_BYTES-1][BYTE_W-1:0] rbuf_q;
	logic                      out_valid_q;
	logic [VALUE_W-1:0]        read_value_q;
	logic [POS_W-1:0]          position_q;
	status_t                   status_q;

	logic [POS_W:0]   end_sum;
	logic [POS_W:0]   align_pos;
	logic [POS_W:0]   cap_bits;
	logic             write_ok;
	logic             read_ok;
	status_t          dec_status;
	logic [7:0]       nb_sum;
	logic             rd_en;
	logic             handle;
	logic             we;
	logic [CNT_W-1:0] hidx;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] waddr;
	logic [BYTE_W-1:0] rdata;
	logic [BYTE_W-1:0] old_byte;
	logic [BYTE_W-1:0] wdata;
	logic [WIN_W-1:0]  rshift;
	logic [VALUE_W-1:0] field_mask;
	logic [VALUE_W-1:0] rv;

	assign cap_bits  = (POS_W + 1)'(CAP_BITS);
	assign end_sum   = {1'b0, pos_q} + (POS_W + 1)'(w_q);
	assign align_pos = {1'b0, pos_q} + (POS_W + 1)'(4'd8 - {1'b0, pos_q[2:0]});
	assign write_ok  = (mode_q == MODE_WRITE) && (w_q != '0) && !wp_q && (end_sum <= cap_bits);
	assign read_ok   = (mode_q == MODE_READ) && (w_q != '0) && (end_sum <= {1'b0, written_q});
	assign nb_sum    = 8'(pos_q[2:0]) + 8'(w_q) + 8'd7;

	always_comb begin
		dec_status = ST_OK;
		unique case (mode_q)
			MODE_WRITE: begin
				if (w_q != '0) begin
					if (wp_q)
						dec_status = ST_PROTECTED;
					else if (end_sum > cap_bits)
						dec_status = ST_CAPACITY;
				end
			end
			MODE_READ: begin
				if ((w_q != '0) && (end_sum > {1'b0, written_q}))
					dec_status = ST_READ_PAST;
			end
			MODE_ALIGN: begin
				if (align_pos > cap_bits)
					dec_status = ST_CAPACITY;
			end
			default: begin
				dec_status = ST_OK;
			end
		endcase
	end

	// Byte access sequence: a read is issued for byte cnt, byte cnt - 1 is handled.
	assign hidx     = cnt_q - CNT_W'(1);
	assign rd_en    = cmd.step && (cnt_q < nb_q);
	assign handle   = cmd.step && (cnt_q != '0);
	assign we       = handle && (mode_q == MODE_WRITE);
	assign raddr    = base_q + ADDR_W'(cnt_q);
	assign waddr    = base_q + ADDR_W'(hidx);
	assign old_byte = rvld_q ? rdata : '0;
	assign wdata    = old_byte | win_q[hidx];

	bfsp_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(CAPACITY_BYTES)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign sts.need_access = write_ok || read_ok;
	assign sts.access_done = cmd.step && (cnt_q == nb_q);
	assign sts.out_free    = !out_valid_q || out_ready;

	assign rshift     = rbuf_q << off_q;
	assign field_mask = ~({VALUE_W{1'b1}} >> w_q);
	assign rv         = rd_ok_q ? unpack_order(rshift[WIN_W-1 -: VALUE_W] & field_mask, w_q)
	                            : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= 1'b0;
			pos_q     <= '0;
			written_q <= '0;
			vld_q     <= '0;
		end else begin
			if (cfg_valid)
				wp_q <= write_protect;
			if (cmd.decide) begin
				unique case (mode_q)
					MODE_WRITE: begin
						if (write_ok) begin
							pos_q <= end_sum[POS_W-1:0];
							if (end_sum[POS_W-1:0] > written_q)
								written_q <= end_sum[POS_W-1:0];
						end
					end
					MODE_READ: begin
						if (read_ok)
							pos_q <= end_sum[POS_W-1:0];
					end
					MODE_ALIGN: begin
						if (align_pos <= cap_bits)
							pos_q <= align_pos[POS_W-1:0];
					end
					MODE_CLEAR: begin
						pos_q     <= '0;
						written_q <= '0;
						vld_q     <= '0;
					end
					MODE_REWIND: begin
						pos_q <= '0;
					end
					default: begin
						pos_q <= pos_q;
					end
				endcase
			end
			if (we)
				vld_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			val_q  <= field_value;
			w_q    <= (field_width > MAX_FIELD_W) ? MAX_FIELD_W : field_width;
		end
		if (cmd.decide) begin
			st_q    <= dec_status;
			rd_ok_q <= read_ok;
			base_q  <= pos_q[ADDR_W+2:3];
			off_q   <= pos_q[2:0];
			nb_q    <= nb_sum[CNT_W+2:3];
			cnt_q   <= '0;
			win_q   <= {pack_order(val_q, w_q), 8'h00} >> pos_q[2:0];
		end
		if (cmd.step)
			cnt_q <= cnt_q + CNT_W'(1);
		if (rd_en)
			rvld_q <= vld_q[raddr];
		if (handle && (mode_q == MODE_READ))
			rbuf_q[hidx] <= old_byte;
		if (cmd.publish) begin
			read_value_q <= rv;
			position_q   <= pos_q;
			status_q     <= st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.publish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid     = out_valid_q;
	assign read_value    = read_value_q;
	assign position_bits = POSITION_OUT_W'(position_q);
	assign status        = status_q;

endmodule

// File: src/bit_field_stream_packer_core.sv
// Top level of the bit field stream packer: controller and datapath.
//
// Input channel (in_valid/in_ready) takes one beat of mode, field_value and
// field_width; the output channel (out_valid/out_ready) returns one beat of
// read_value, position_bits and status for every input beat, in order.
// The configuration channel (cfg_valid/cfg_ready) writes write_protect and is
// always ready; write it only while no beat is in flight.
// Writes and reads touch nb = ceil((position mod 8 + width) / 8) store bytes,
// one to nine, one byte per cycle through the byte-wide store ports; align,
// clear, rewind, rejected and zero-width beats skip the byte access.
// Reset clears the position, the written length, write_protect and the
// per-byte valid bits, so the whole store reads as zero at once; clear mode
// clears all of these but write_protect.
// A result waits in the output register while the receiver stalls; the next
// beat is accepted and worked on, and it holds in its final step until the
// output register frees.
module bit_field_stream_packer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bfsp_pkg::MODE_W-1:0]         mode,
	input  logic [bfsp_pkg::VALUE_W-1:0]        field_value,
	input  logic [bfsp_pkg::WIDTH_W-1:0]        field_width,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bfsp_pkg::VALUE_W-1:0]        read_value,
	output logic [bfsp_pkg::POSITION_OUT_W-1:0] position_bits,
	output logic [bfsp_pkg::STATUS_W-1:0]       status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                write_protect
);
	import bfsp_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t sts;

	assign cfg_ready = 1'b1;

	bfsp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bfsp_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.write_protect(write_protect),
		.mode         (mode),
		.field_value  (field_value),
		.field_width  (field_width),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_value   (read_value),
		.position_bits(position_bits),
		.status       (status)
	);

endmodule
